[design/grid_neighbor_expander_assert.svh]
// Assertion macros shared by the grid neighbor expander modules.
`ifndef GRID_NEIGHBOR_EXPANDER_ASSERT_SVH
`define GRID_NEIGHBOR_EXPANDER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GNE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define GNE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/gne_pkg.sv]
// Types, constants and sizes shared by the grid neighbor expander.
`timescale 1ns / 1ps

package gne_pkg;

    localparam int MAX_CELLS = 65536;
    localparam int MAX_SIDE  = 256;

    localparam int CELL_W    = $clog2(MAX_CELLS);
    localparam int COL_W     = $clog2(MAX_SIDE);
    localparam int SIDE_W    = COL_W + 1;
    localparam int ROW_W     = CELL_W;

    localparam int SCALE_W   = 16;
    localparam int COST_W    = 17;
    localparam int DIR_W     = 3;
    localparam int DIR_CNT_W = DIR_W + 1;
    localparam int IDX_W     = 2;
    localparam int CFG_DW    = 16;

    localparam int DIV_STEPS = CELL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    localparam logic [DIR_CNT_W-1:0] DIRS_FOUR  = DIR_CNT_W'(4);
    localparam logic [DIR_CNT_W-1:0] DIRS_EIGHT = DIR_CNT_W'(8);

    localparam int X7_W        = SCALE_W + 3;
    localparam int DIAG_SHIFT  = 22;
    localparam int DIAG_PROD_W = 2 * X7_W + 1;
    localparam logic [DIAG_PROD_W-1:0] DIAG_MUL =
        DIAG_PROD_W'((64'd1 << DIAG_SHIFT) / 5 + 1);

    localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);
    localparam logic [SIDE_W-1:0] SIDE_ONE = SIDE_W'(1);

    localparam logic [IDX_W-1:0] REG_GRID_ROWS       = 2'd0;
    localparam logic [IDX_W-1:0] REG_GRID_COLS       = 2'd1;
    localparam logic [IDX_W-1:0] REG_EIGHT_NEIGHBORS = 2'd2;
    localparam logic [IDX_W-1:0] REG_COST_SCALE      = 2'd3;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_EXPAND = 1'b1;

    typedef enum logic [1:0] {
        STEP_ZERO,
        STEP_NEG,
        STEP_POS
    } t_step;

    localparam t_step STEP_ROW [8] = '{STEP_ZERO, STEP_ZERO, STEP_NEG, STEP_POS,
                                       STEP_NEG, STEP_NEG, STEP_POS, STEP_POS};
    localparam t_step STEP_COL [8] = '{STEP_NEG, STEP_POS, STEP_ZERO, STEP_ZERO,
                                       STEP_NEG, STEP_POS, STEP_NEG, STEP_POS};

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic              req_type;
        logic [CELL_W-1:0] cell_req;
        logic              occupied;
    } t_req;

    typedef struct packed {
        logic [CELL_W-1:0] neighbor;
        logic [COST_W-1:0] step_cost;
        logic [DIR_W-1:0]  direction;
        logic              found;
        logic              last;
    } t_res;

    typedef struct packed {
        logic [SIDE_W-1:0]  rows_eff;
        logic [SIDE_W-1:0]  cols_eff;
        logic               eight;
        logic [SCALE_W-1:0] scale;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic capture;
        logic div_step;
        logic issue;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic dirs_done;
        logic probe_pending;
    } t_dp_st;

endpackage

[design/gne_ctrl.sv]
// Controller state machine: occupancy loads, division steps, neighbor scan and final result.
`timescale 1ns / 1ps

module gne_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_req_type,
    input  gne_pkg::t_dp_st i_st,
    output gne_pkg::t_dp_cmd o_cmd,
    output logic            o_busy
);

    gne_pkg::t_state r_state, n_state;
    logic [gne_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gne_pkg::S_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        o_busy    = 1'b1;
        unique case (r_state)
            gne_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_req_type == gne_pkg::REQ_EXPAND) begin
                        o_cmd.capture = 1'b1;
                        n_div_cnt     = '0;
                        n_state       = gne_pkg::S_DIV;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            gne_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + 1'b1;
                if (r_div_cnt == gne_pkg::DIV_LAST) begin
                    n_state = gne_pkg::S_SCAN;
                end
            end
            gne_pkg::S_SCAN: begin
                o_cmd.issue = !i_st.dirs_done;
                if (i_st.dirs_done && !i_st.probe_pending) begin
                    n_state = gne_pkg::S_FINISH;
                end
            end
            gne_pkg::S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = gne_pkg::S_IDLE;
            end
            default: begin
                n_state = gne_pkg::S_IDLE;
            end
        endcase
    end

`include "grid_neighbor_expander_assert.svh"

    `GNE_ASSERT_NEXT(a_expand_goes_busy, i_start && !o_busy && i_req_type, o_busy, "expand not taken")
    `GNE_ASSERT_NEXT(a_finish_to_idle, r_state == gne_pkg::S_FINISH, !o_busy, "finish did not release")
    `GNE_ASSERT_IMPL(a_scan_not_finish, o_cmd.issue, !o_cmd.finish && !o_cmd.div_step, "command overlap")

endmodule

[design/gne_dp.sv]
// Datapath: occupancy store, serial divider, neighbor probe and result register.
`timescale 1ns / 1ps

module gne_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gne_pkg::t_dp_cmd i_cmd,
    input  gne_pkg::t_cfg    i_cfg,
    input  gne_pkg::t_req    i_req,
    output gne_pkg::t_dp_st  o_st,
    output gne_pkg::t_res    o_res,
    output logic             o_res_strobe
);

    logic r_occ [gne_pkg::MAX_CELLS];
    logic r_rd;

    logic [gne_pkg::CELL_W-1:0]  r_cell;
    logic [gne_pkg::ROW_W-1:0]   r_quo;
    logic [gne_pkg::COL_W-1:0]   r_rem;
    logic [gne_pkg::COST_W-1:0]  r_diag;
    logic [gne_pkg::DIR_CNT_W-1:0] r_dir;

    logic                        r_p_valid;
    logic                        r_p_inb;
    logic [gne_pkg::CELL_W-1:0]  r_p_cell;
    logic [gne_pkg::DIR_W-1:0]   r_p_dir;

    logic                        r_pend_valid;
    gne_pkg::t_res               r_pend;
    gne_pkg::t_res               r_res;
    logic                        r_strobe;

    logic [gne_pkg::SIDE_W-1:0]  trial;
    logic [gne_pkg::SIDE_W-1:0]  trial_sub;
    logic                        qbit;

    logic [gne_pkg::X7_W-1:0]        x7;
    logic [gne_pkg::DIAG_PROD_W-1:0] diag_prod;

    logic [gne_pkg::DIR_W-1:0]   dir;
    gne_pkg::t_step              dr;
    gne_pkg::t_step              dc;
    logic [gne_pkg::ROW_W:0]     row_ext;
    logic [gne_pkg::ROW_W:0]     rows_ext;
    logic [gne_pkg::SIDE_W-1:0]  col_ext;
    logic                        row_ok;
    logic                        col_ok;
    logic [gne_pkg::CELL_W:0]    base;
    logic [gne_pkg::CELL_W:0]    ncell;
    logic [gne_pkg::DIR_CNT_W-1:0] ndirs;
    logic                        hit;
    logic [gne_pkg::COST_W-1:0]  cost;
    gne_pkg::t_res               fin_res;

    always_comb begin
        trial     = {r_rem, r_quo[gne_pkg::ROW_W-1]};
        qbit      = (trial >= i_cfg.cols_eff);
        trial_sub = trial - i_cfg.cols_eff;
    end

    always_comb begin
        x7        = {i_cfg.scale, 3'b000} - gne_pkg::X7_W'(i_cfg.scale);
        diag_prod = gne_pkg::DIAG_PROD_W'(x7) * gne_pkg::DIAG_MUL;
    end

    always_comb begin
        dir      = r_dir[gne_pkg::DIR_W-1:0];
        dr       = gne_pkg::STEP_ROW[dir];
        dc       = gne_pkg::STEP_COL[dir];
        row_ext  = {1'b0, r_quo};
        rows_ext = (gne_pkg::ROW_W + 1)'(i_cfg.rows_eff);
        col_ext  = {1'b0, r_rem};
        row_ok   = 1'b0;
        col_ok   = 1'b0;
        base     = {1'b0, r_cell};
        ncell    = base;
        unique case (dr)
            gne_pkg::STEP_NEG: begin
                row_ok = (r_quo != '0) && (row_ext <= rows_ext);
                base   = {1'b0, r_cell} - (gne_pkg::CELL_W + 1)'(i_cfg.cols_eff);
            end
            gne_pkg::STEP_POS: begin
                row_ok = ((row_ext + 1'b1) < rows_ext);
                base   = {1'b0, r_cell} + (gne_pkg::CELL_W + 1)'(i_cfg.cols_eff);
            end
            default: begin
                row_ok = (row_ext < rows_ext);
                base   = {1'b0, r_cell};
            end
        endcase
        unique case (dc)
            gne_pkg::STEP_NEG: begin
                col_ok = (r_rem != '0);
                ncell  = base - 1'b1;
            end
            gne_pkg::STEP_POS: begin
                col_ok = ((col_ext + 1'b1) < i_cfg.cols_eff);
                ncell  = base + 1'b1;
            end
            default: begin
                col_ok = 1'b1;
                ncell  = base;
            end
        endcase
    end

    always_comb begin
        ndirs = i_cfg.eight ? gne_pkg::DIRS_EIGHT : gne_pkg::DIRS_FOUR;
        hit   = r_p_valid && r_p_inb && !r_rd;
        cost  = r_p_dir[gne_pkg::DIR_W-1] ? r_diag : gne_pkg::COST_W'(i_cfg.scale);
    end

    always_comb begin
        if (r_pend_valid) begin
            fin_res = r_pend;
        end else begin
            fin_res = '0;
        end
        fin_res.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_occ[i_req.cell_req] <= i_req.occupied;
        end
        if (i_cmd.issue) begin
            r_rd <= r_occ[ncell[gne_pkg::CELL_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_diag <= diag_prod[gne_pkg::DIAG_SHIFT +: gne_pkg::COST_W];
        if (i_cmd.capture) begin
            r_cell <= i_req.cell_req;
            r_quo  <= i_req.cell_req;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[gne_pkg::ROW_W-2:0], qbit};
            r_rem <= qbit ? trial_sub[gne_pkg::COL_W-1:0] : trial[gne_pkg::COL_W-1:0];
        end
        if (i_cmd.issue) begin
            r_p_inb  <= row_ok && col_ok;
            r_p_cell <= ncell[gne_pkg::CELL_W-1:0];
            r_p_dir  <= dir;
        end
        if (hit) begin
            r_pend.neighbor  <= r_p_cell;
            r_pend.step_cost <= cost;
            r_pend.direction <= r_p_dir;
            r_pend.found     <= 1'b1;
            r_pend.last      <= 1'b0;
        end
        if (hit && r_pend_valid) begin
            r_res <= r_pend;
        end else if (i_cmd.finish) begin
            r_res <= fin_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir        <= '0;
            r_p_valid    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_p_valid <= i_cmd.issue;
            r_strobe  <= (hit && r_pend_valid) || i_cmd.finish;
            if (i_cmd.capture) begin
                r_dir        <= '0;
                r_pend_valid <= 1'b0;
            end else begin
                if (i_cmd.issue) begin
                    r_dir <= r_dir + 1'b1;
                end
                if (hit) begin
                    r_pend_valid <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_st.dirs_done     = (r_dir == ndirs);
        o_st.probe_pending = r_p_valid;
        o_res              = r_res;
        o_res_strobe       = r_strobe;
    end

`include "grid_neighbor_expander_assert.svh"

    `GNE_ASSERT_IMPL(a_none_is_last, r_strobe && !r_res.found, r_res.last, "empty result not last")
    `GNE_ASSERT_IMPL(a_early_keeps_pend, r_strobe && !r_res.last, r_pend_valid, "early result without successor")
    `GNE_ASSERT_IMPL(a_issue_in_range, i_cmd.issue, r_dir < ndirs, "probe past last direction")

endmodule

[design/grid_neighbor_expander.sv]
// Top level of the grid neighbor expander: configuration registers and wiring.
//
// Usage:
//   Item channel: drive i_req and raise start while busy is low; the
//   transaction is taken at that clock edge. A load (req_type 0) writes one
//   occupancy bit in that cycle, gives no result and leaves busy low, so
//   loads may follow back to back. An expand (req_type 1) raises busy.
//   Results: each appears on o_res for one cycle with o_res_strobe high,
//   in order left, right, up, down, then the diagonals; the final one has
//   last set, and a cell with no free neighbor gives one result with found
//   clear. The receiver cannot stall; results are never held.
//   Steps of an expand: restoring division of the cell number by the column
//   count (one quotient bit per cycle), then one probe per direction, then a
//   drain of the occupancy read, then a closing step. busy stays high through
//   the closing step; the last strobe comes in the first cycle with busy low,
//   when a new item can already start.
//   Configuration: i_cfg_valid with i_cfg_index/i_cfg_data; o_cfg_ready is
//   always high. Write only while idle. Reset restores 256 x 256, four
//   neighbors, scale 1.0; occupancy contents are undefined until loaded.
`timescale 1ns / 1ps

module grid_neighbor_expander (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  gne_pkg::t_req                 i_req,
    output gne_pkg::t_res                 o_res,
    output logic                          o_res_strobe,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gne_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [gne_pkg::CFG_DW-1:0]    i_cfg_data
);

    logic [gne_pkg::SIDE_W-1:0]  r_grid_rows;
    logic [gne_pkg::SIDE_W-1:0]  r_grid_cols;
    logic                        r_eight;
    logic [gne_pkg::SCALE_W-1:0] r_scale;

    gne_pkg::t_cfg    cfg;
    gne_pkg::t_dp_cmd cmd;
    gne_pkg::t_dp_st  st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= gne_pkg::SIDE_MAX;
            r_grid_cols <= gne_pkg::SIDE_MAX;
            r_eight     <= 1'b0;
            r_scale     <= gne_pkg::SCALE_W'(256);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gne_pkg::REG_GRID_ROWS:       r_grid_rows <= i_cfg_data[gne_pkg::SIDE_W-1:0];
                gne_pkg::REG_GRID_COLS:       r_grid_cols <= i_cfg_data[gne_pkg::SIDE_W-1:0];
                gne_pkg::REG_EIGHT_NEIGHBORS: r_eight     <= i_cfg_data[0];
                gne_pkg::REG_COST_SCALE:      r_scale     <= i_cfg_data[gne_pkg::SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_cfg_ready = 1'b1;
        if (r_grid_rows == '0) begin
            cfg.rows_eff = gne_pkg::SIDE_ONE;
        end else if (r_grid_rows > gne_pkg::SIDE_MAX) begin
            cfg.rows_eff = gne_pkg::SIDE_MAX;
        end else begin
            cfg.rows_eff = r_grid_rows;
        end
        if (r_grid_cols == '0) begin
            cfg.cols_eff = gne_pkg::SIDE_ONE;
        end else if (r_grid_cols > gne_pkg::SIDE_MAX) begin
            cfg.cols_eff = gne_pkg::SIDE_MAX;
        end else begin
            cfg.cols_eff = r_grid_cols;
        end
        cfg.eight = r_eight;
        cfg.scale = r_scale;
    end

    gne_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    gne_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg        (cfg),
        .i_req        (i_req),
        .o_st         (st),
        .o_res        (o_res),
        .o_res_strobe (o_res_strobe)
    );

endmodule

[tb/sv/grid_neighbor_expander_tb.sv]
// Self-checking testbench for the grid neighbor expander: directed and random expansions.
`timescale 1ns / 1ps

module grid_neighbor_expander_tb;
    import gne_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 230;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_req               i_req;
    t_res               o_res;
    logic               o_res_strobe;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index;
    logic [CFG_DW-1:0]  i_cfg_data;

    grid_neighbor_expander i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_res        (o_res),
        .o_res_strobe (o_res_strobe),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    logic [8:0]         grid_rows_reg;
    logic [8:0]         grid_cols_reg;
    logic               eight_reg;
    logic [15:0]        scale_reg;
    bit                 occ_map [0:MAX_CELLS-1];
    bit                 cell_loaded [0:MAX_CELLS-1];

    t_res               expected_neighbors [$];
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    int                 burst_left = 0;
    int                 blocked_pct = 30;
    int                 items_sent = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int side_of(input logic [8:0] v);
        if (v == 9'd0) return 1;
        if (int'(v) > MAX_SIDE) return MAX_SIDE;
        return int'(v);
    endfunction

    function automatic int row_step(input int d);
        case (d)
            2, 4, 5: return -1;
            3, 6, 7: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic int col_step(input int d);
        case (d)
            0, 4, 6: return -1;
            1, 5, 7: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic void queue_result(input t_res res);
        expected_neighbors = {expected_neighbors, res};
    endfunction

    function automatic void predict_neighbors(input logic [CELL_W-1:0] cell_num);
        int   rows;
        int   cols;
        int   r;
        int   c;
        int   nr;
        int   nc;
        int   ncell;
        int   dirs;
        int   hits;
        t_res res;
        t_res hit_buf [8];
        rows = side_of(grid_rows_reg);
        cols = side_of(grid_cols_reg);
        r = int'(cell_num) / cols;
        c = int'(cell_num) % cols;
        dirs = eight_reg ? 8 : 4;
        hits = 0;
        for (int d = 0; d < dirs; d++) begin
            nr = r + row_step(d);
            nc = c + col_step(d);
            if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
            ncell = nr * cols + nc;
            if (ncell >= MAX_CELLS || occ_map[ncell]) continue;
            res.neighbor  = CELL_W'(ncell);
            res.step_cost = (d < 4) ? COST_W'(int'(scale_reg))
                                    : COST_W'((int'(scale_reg) * 7) / 5);
            res.direction = DIR_W'(d);
            res.found     = 1'b1;
            res.last      = 1'b0;
            hit_buf[hits] = res;
            hits++;
        end
        if (hits == 0) begin
            res = '0;
            res.last = 1'b1;
            queue_result(res);
        end else begin
            hit_buf[hits-1].last = 1'b1;
            for (int i = 0; i < hits; i++) queue_result(hit_buf[i]);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n === 1'b1 && o_res_strobe === 1'b1) begin
            if (expected_neighbors.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: %h", o_res));
            end else begin
                want = expected_neighbors.pop_front();
                if (o_res.neighbor !== want.neighbor)
                    report_mismatch($sformatf("neighbor got %0d want %0d",
                                              o_res.neighbor, want.neighbor));
                if (o_res.step_cost !== want.step_cost)
                    report_mismatch($sformatf("step_cost got %0d want %0d",
                                              o_res.step_cost, want.step_cost));
                if (o_res.direction !== want.direction)
                    report_mismatch($sformatf("direction got %0d want %0d",
                                              o_res.direction, want.direction));
                if (o_res.found !== want.found)
                    report_mismatch($sformatf("found got %0b want %0b",
                                              o_res.found, want.found));
                if (o_res.last !== want.last)
                    report_mismatch($sformatf("last got %0b want %0b",
                                              o_res.last, want.last));
            end
        end
    end

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            idle_cycles($urandom_range(1, 30));
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_neighbors.size() != 0);
    endtask

    task automatic send_item(input t_req item);
        start <= 1'b1;
        i_req <= item;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        if (item.req_type == REQ_LOAD) begin
            occ_map[item.cell_req]     = item.occupied;
            cell_loaded[item.cell_req] = 1'b1;
        end else begin
            predict_neighbors(item.cell_req);
        end
        pace();
    endtask

    task automatic load_cell(input int cell_num, input logic occ);
        t_req item;
        item.req_type = REQ_LOAD;
        item.cell_req = CELL_W'(cell_num);
        item.occupied = occ;
        send_item(item);
    endtask

    // Load any in-grid neighbor that has never been written, so no in-grid probe reads an unknown cell.
    task automatic ready_neighbors(input int cell_num);
        int rows;
        int cols;
        int r;
        int c;
        int nr;
        int nc;
        int ncell;
        rows = side_of(grid_rows_reg);
        cols = side_of(grid_cols_reg);
        r = cell_num / cols;
        c = cell_num % cols;
        for (int d = 0; d < 8; d++) begin
            nr = r + row_step(d);
            nc = c + col_step(d);
            if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
            ncell = nr * cols + nc;
            if (ncell < MAX_CELLS && !cell_loaded[ncell])
                load_cell(ncell, $urandom_range(0, 99) < blocked_pct);
        end
    endtask

    task automatic expand_cell(input int cell_num);
        t_req item;
        ready_neighbors(cell_num);
        item.req_type = REQ_EXPAND;
        item.cell_req = CELL_W'(cell_num);
        item.occupied = 1'($urandom);
        send_item(item);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_GRID_ROWS:       grid_rows_reg = data[8:0];
            REG_GRID_COLS:       grid_cols_reg = data[8:0];
            REG_EIGHT_NEIGHBORS: eight_reg     = data[0];
            REG_COST_SCALE:      scale_reg     = data;
            default: ;
        endcase
    endtask

    // Drain, settle, then write all four registers with junk in the unused data bits.
    task automatic apply_config(input logic [8:0] rows, input logic [8:0] cols,
                                input logic eight, input logic [15:0] scale);
        drain();
        idle_cycles(4);
        write_reg(REG_GRID_ROWS, (16'($urandom) & 16'hFE00) | 16'(rows));
        write_reg(REG_GRID_COLS, (16'($urandom) & 16'hFE00) | 16'(cols));
        write_reg(REG_EIGHT_NEIGHBORS, (16'($urandom) & 16'hFFFE) | 16'(eight));
        write_reg(REG_COST_SCALE, scale);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_default_grid();
        expand_cell(0);
        expand_cell(65535);
        expand_cell(257);
    endtask

    task automatic test_blocked_cell();
        load_cell(256, 1'b1);
        load_cell(258, 1'b1);
        load_cell(1, 1'b1);
        load_cell(513, 1'b1);
        expand_cell(257);
        load_cell(258, 1'b0);
        expand_cell(257);
    endtask

    task automatic test_eight_connected();
        apply_config(9'd5, 9'd7, 1'b1, 16'hFFFF);
        expand_cell(17);
        expand_cell(0);
        expand_cell(34);
        expand_cell(7);
        apply_config(9'd5, 9'd7, 1'b1, 16'd0);
        expand_cell(17);
    endtask

    task automatic test_side_clamp();
        apply_config(9'd0, 9'd0, 1'b1, 16'd256);
        expand_cell(0);
        expand_cell(65535);
        apply_config(9'd511, 9'd300, 1'b0, 16'd1000);
        expand_cell(65535);
        expand_cell(256);
    endtask

    task automatic test_past_grid_cell();
        apply_config(9'd3, 9'd4, 1'b1, 16'd500);
        expand_cell(12);
        expand_cell(15);
        expand_cell(65535);
    endtask

    function automatic logic [8:0] pick_side();
        case ($urandom_range(0, 9))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd256;
            3:       return 9'($urandom_range(257, 511));
            4:       return 9'd2;
            default: return 9'($urandom_range(3, 12));
        endcase
    endfunction

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_random_traffic();
        int rows;
        int cols;
        int cell_num;
        int sel;
        int phase_end;
        for (int phase = 0; phase < 8; phase++) begin
            apply_config(pick_side(), pick_side(), 1'($urandom), pick_scale());
            blocked_pct = $urandom_range(0, 70);
            rows = side_of(grid_rows_reg);
            cols = side_of(grid_cols_reg);
            phase_end = items_sent + (ITEM_TARGET - items_sent) / (8 - phase);
            while (items_sent < phase_end) begin
                sel = $urandom_range(0, 99);
                if (sel < 70) begin
                    cell_num = $urandom_range(0, rows) * cols + $urandom_range(0, cols - 1);
                    if (cell_num >= MAX_CELLS) cell_num = MAX_CELLS - 1;
                    expand_cell(cell_num);
                end else if (sel < 85) begin
                    cell_num = $urandom_range(0, 1) ? $urandom_range(0, rows * cols - 1)
                                                    : int'(16'($urandom));
                    load_cell(cell_num, 1'($urandom));
                end else begin
                    expand_cell(int'(16'($urandom)));
                end
                if ($urandom_range(0, 29) == 0) drain();
            end
        end
    endtask

    task automatic finish_run();
        drain();
        repeat (40) @(posedge i_clk);
        if (expected_neighbors.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_neighbors.size()));
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    endtask

    initial begin
        start       <= 1'b0;
        i_req       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        grid_rows_reg = 9'd256;
        grid_cols_reg = 9'd256;
        eight_reg     = 1'b0;
        scale_reg     = 16'd256;
        for (int i = 0; i < MAX_CELLS; i++) begin
            occ_map[i]     = 1'b0;
            cell_loaded[i] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_grid();
        test_blocked_cell();
        test_eight_connected();
        test_side_clamp();
        test_past_grid_cell();
        test_random_traffic();
        finish_run();
    end

endmodule

[grid_neighbor_expander.f]
+incdir+design
design/gne_pkg.sv
design/gne_ctrl.sv
design/gne_dp.sv
design/grid_neighbor_expander.sv
tb/sv/grid_neighbor_expander_tb.sv
